### rtl/psched_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
`default_nettype none
package psched_pkg;

  localparam int unsigned SlotW  = 4;
  localparam int unsigned BurstW = 16;
  localparam int unsigned PrioW  = 8;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 56;
  localparam logic [TimeW-1:0] ClockMax = {TimeW{1'b1}};

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  // A running slot behaves exactly like a ready one in every decision, so the
  // two share one code.
  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_NEW   = 2'd1,
    SLOT_READY = 2'd2,
    SLOT_DONE  = 2'd3
  } slot_st_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_FETCH,
    ST_UPDATE,
    ST_OUT
  } ctrl_st_t;

  typedef struct packed {
    logic capture;
    logic load_exec;
    logic scan_start;
    logic scan_run;
    logic fetch;
    logic update;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

### rtl/psched_ctrl.sv
// Sequencing state machine of the scheduler.
`default_nettype none
module psched_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             in_op,
  output logic                  in_ready,
  input  wire psched_pkg::sts_t sts,
  output psched_pkg::cmd_t      cmd
);

  psched_pkg::ctrl_st_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psched_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      psched_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_op == psched_pkg::OP_LOAD) begin
            state_next = psched_pkg::ST_LOAD;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = psched_pkg::ST_SCAN;
          end
        end
      end
      psched_pkg::ST_LOAD: begin
        cmd.load_exec = 1'b1;
        state_next    = psched_pkg::ST_OUT;
      end
      psched_pkg::ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_last) begin
          state_next = psched_pkg::ST_FETCH;
        end
      end
      psched_pkg::ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = psched_pkg::ST_UPDATE;
      end
      psched_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = psched_pkg::ST_OUT;
      end
      psched_pkg::ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = psched_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = psched_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == psched_pkg::ST_IDLE)
    else $error("input taken outside idle");
  a_tick_goes_scan: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_op == psched_pkg::OP_TICK) |=> state == psched_pkg::ST_SCAN)
    else $error("tick did not start a scan");
  a_fetch_then_update: assert property (@(posedge clk) disable iff (rst)
    cmd.fetch |=> cmd.update)
    else $error("fetch not followed by update");
`endif

endmodule
`default_nettype wire

### rtl/psched_dp.sv
// Slot tables, priority scan, slot update and output register of the scheduler.
`default_nettype none
module psched_dp #(
  parameter int unsigned MAX_SLOTS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire psched_pkg::cmd_t                    cmd,
  output psched_pkg::sts_t                         sts,
  input  wire logic [psched_pkg::InDataW-1:0]      in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [psched_pkg::OutDataW-1:0]          out_data,
  output logic [1:0]                               out_flags
);

  localparam int unsigned IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned EW = psched_pkg::BurstW + psched_pkg::PrioW + psched_pkg::TimeW;

  // Captured load word.
  logic [psched_pkg::SlotW-1:0]  ld_slot;
  logic [psched_pkg::BurstW-1:0] ld_burst;
  logic [psched_pkg::PrioW-1:0]  ld_prio;
  logic [psched_pkg::TimeW-1:0]  ld_arr;

  // Slot tables: burst, priority and arrival in one memory, remaining time in another.
  logic [EW-1:0]                 ent_mem [MAX_SLOTS];
  logic [psched_pkg::BurstW-1:0] rem_mem [MAX_SLOTS];
  logic [EW-1:0]                 ent_q;
  logic [psched_pkg::BurstW-1:0] rem_q;
  psched_pkg::slot_st_t          slot_st [MAX_SLOTS];

  logic [psched_pkg::TimeW-1:0]  clock_now;
  logic [CW-1:0]                 pend_cnt;

  logic [CW-1:0]                 scan_cnt;
  logic                          chk_valid;
  logic [IW-1:0]                 chk_idx;
  logic                          found;
  logic [psched_pkg::PrioW-1:0]  best;
  logic [IW-1:0]                 pick;

  logic [psched_pkg::SlotW-1:0]  res_running;
  logic                          res_idle;
  logic                          res_finished;
  logic [psched_pkg::TimeW-1:0]  res_turn;
  logic [psched_pkg::TimeW-1:0]  res_wait;

  logic [6:0]                    slot_ext;
  logic [6:0]                    pick_ext;
  logic                          ld_in_range;
  logic [IW-1:0]                 ld_idx;
  logic                          rd_en;
  logic [IW-1:0]                 rd_addr;
  logic [psched_pkg::BurstW-1:0] ent_burst;
  logic [psched_pkg::PrioW-1:0]  ent_prio;
  logic [psched_pkg::TimeW-1:0]  ent_arr;
  psched_pkg::slot_st_t          chk_st;
  logic                          chk_admit;
  logic                          chk_elig;
  logic                          ld_old_pend;
  logic                          ld_new_pend;
  logic [psched_pkg::BurstW-1:0] rem_dec;
  logic [psched_pkg::TimeW-1:0]  clock_inc;
  logic [psched_pkg::TimeW-1:0]  turn_calc;
  logic                          fin_now;

  assign slot_ext    = 7'(ld_slot);
  assign pick_ext    = 7'(pick);
  assign ld_in_range = slot_ext < 7'(MAX_SLOTS);
  assign ld_idx      = slot_ext[IW-1:0];
  assign rd_en       = cmd.fetch || (cmd.scan_run && scan_cnt < CW'(MAX_SLOTS));
  assign rd_addr     = cmd.fetch ? pick : scan_cnt[IW-1:0];

  assign {ent_burst, ent_prio, ent_arr} = ent_q;

  assign chk_st    = slot_st[chk_idx];
  assign chk_admit = chk_st == psched_pkg::SLOT_NEW && ent_arr <= clock_now;
  assign chk_elig  = chk_admit || chk_st == psched_pkg::SLOT_READY;

  assign ld_old_pend = slot_st[ld_idx] == psched_pkg::SLOT_NEW ||
                       slot_st[ld_idx] == psched_pkg::SLOT_READY;
  assign ld_new_pend = ld_burst != '0;

  assign rem_dec   = (rem_q != '0) ? rem_q - 1'b1 : rem_q;
  assign clock_inc = (clock_now != psched_pkg::ClockMax) ? clock_now + 1'b1 : clock_now;
  assign turn_calc = clock_inc - ent_arr;
  assign fin_now   = found && rem_dec == '0;

  assign sts.scan_last = chk_valid && chk_idx == IW'(MAX_SLOTS - 1);
  assign sts.out_free  = !out_valid || out_ready;

  // Memories: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.load_exec && ld_in_range && ld_new_pend) begin
      ent_mem[ld_idx] <= {ld_burst, ld_prio, ld_arr};
    end
    if (rd_en) begin
      ent_q <= ent_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_exec && ld_in_range && ld_new_pend) begin
      rem_mem[ld_idx] <= ld_burst;
    end else if (cmd.update && found) begin
      rem_mem[pick] <= rem_dec;
    end
    if (rd_en) begin
      rem_q <= rem_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ld_slot  <= in_data[3:0];
      ld_burst <= in_data[19:4];
      ld_prio  <= in_data[27:20];
      ld_arr   <= in_data[43:28];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        slot_st[i] <= psched_pkg::SLOT_EMPTY;
      end
      clock_now <= '0;
      pend_cnt  <= '0;
      scan_cnt  <= '0;
      chk_valid <= 1'b0;
      found     <= 1'b0;
    end else begin
      if (cmd.load_exec && ld_in_range) begin
        slot_st[ld_idx] <= ld_new_pend ? psched_pkg::SLOT_NEW : psched_pkg::SLOT_EMPTY;
        pend_cnt <= pend_cnt - CW'(ld_old_pend) + CW'(ld_new_pend);
      end

      if (cmd.scan_start) begin
        scan_cnt  <= '0;
        chk_valid <= 1'b0;
        found     <= 1'b0;
      end else begin
        chk_valid <= cmd.scan_run && scan_cnt < CW'(MAX_SLOTS);
        if (cmd.scan_run && scan_cnt < CW'(MAX_SLOTS)) begin
          scan_cnt <= scan_cnt + 1'b1;
        end
        // Strict compare keeps the lowest index among equal priorities.
        if (chk_valid) begin
          if (chk_admit) begin
            slot_st[chk_idx] <= psched_pkg::SLOT_READY;
          end
          if (chk_elig && (!found || ent_prio < best)) begin
            found <= 1'b1;
            best  <= ent_prio;
            pick  <= chk_idx;
          end
        end
      end

      if (cmd.update) begin
        clock_now <= clock_inc;
        if (fin_now) begin
          slot_st[pick] <= psched_pkg::SLOT_DONE;
          pend_cnt      <= pend_cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= scan_cnt[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_exec) begin
      res_running  <= '0;
      res_idle     <= 1'b1;
      res_finished <= 1'b0;
      res_turn     <= '0;
      res_wait     <= '0;
    end else if (cmd.update) begin
      res_running  <= found ? pick_ext[3:0] : '0;
      res_idle     <= !found;
      res_finished <= fin_now;
      res_turn     <= fin_now ? turn_calc : '0;
      res_wait     <= (fin_now && turn_calc > ent_burst) ? turn_calc - ent_burst : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data  <= {3'b000, pend_cnt == '0, res_wait, res_turn, res_running, clock_now};
      out_flags <= {res_finished, res_idle};
    end
  end

`ifndef SYNTHESIS
  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend_cnt <= CW'(MAX_SLOTS))
    else $error("pending count above slot count");
  a_clock_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> clock_now >= $past(clock_now))
    else $error("clock went backward");
  a_finish_runs: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.update) && res_finished |-> !res_idle)
    else $error("finished word marked idle");
  a_scan_bounded: assert property (@(posedge clk) disable iff (rst)
    scan_cnt <= CW'(MAX_SLOTS))
    else $error("scan counter overran");
`endif

endmodule
`default_nettype wire

### rtl/preemptive_priority_scheduler_unit.sv
// Top level of the preemptive priority scheduler.
`default_nettype none
// Preemptive priority scheduler over MAX_SLOTS task slots. A load word
// (s_tuser 0) writes one slot and then hands its result to the output register.
// A tick word (s_tuser 1) steps through the table: the slot table sits in
// memories with one read port, so the tick reads one slot a cycle to admit
// arrivals and find the lowest priority value, then reads the chosen slot
// again to update it. One word is worked on at a time; a finished result
// waits in the output register without holding up the next input word. After
// reset all slots are empty and the clock is zero; no clearing pass is needed.
module preemptive_priority_scheduler_unit #(
  parameter int unsigned MAX_SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // slot[3:0], burst[19:4], priority_req[27:20], arrival[43:28], zero fill
  input  wire logic [47:0] s_tdata,
  // operation[0]
  input  wire logic        s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // time_now[15:0], running_slot[19:16], turnaround[35:20], waiting[51:36],
  // all_done[52], zero fill
  output logic [55:0]      m_tdata,
  // idle[0], finished[1]
  output logic [1:0]       m_tuser
);

  psched_pkg::cmd_t cmd;
  psched_pkg::sts_t sts;

  psched_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_op    (s_tuser),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  psched_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_flags (m_tuser)
  );

endmodule
`default_nettype wire
